>>> design/sspq_pkg.sv
package sspq_pkg;

  localparam int unsigned CAPACITY_DEF       = 16;
  localparam int unsigned DATA_WIDTH_DEF     = 16;
  localparam int unsigned PRIORITY_WIDTH_DEF = 4;

  typedef enum logic [2:0] {
    KIND_INSERT   = 3'd0,
    KIND_POP      = 3'd1,
    KIND_EQUAL    = 3'd2,
    KIND_AT_LEAST = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_REMOVE = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    insert_en;
    logic    clear_en;
    logic    load_en;
    logic    shift_en;
    logic    emit_item;
    logic    emit_status;
    status_e status_code;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic front_hit;
    logic next_hit;
  } dp_status_t;

endpackage

>>> design/sspq_datapath.sv
module sspq_datapath
  import sspq_pkg::*;
#(
  parameter int unsigned CAPACITY       = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output dp_status_t                status_o,
  input  logic [2:0]                kind_i,
  input  logic [DATA_WIDTH-1:0]     item_data_i,
  input  logic [PRIORITY_WIDTH-1:0] item_priority_i,
  output logic [DATA_WIDTH-1:0]     out_data_o,
  output logic [PRIORITY_WIDTH-1:0] out_priority_o,
  output logic [1:0]                status_code_o,
  output logic                      last_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  function automatic logic prio_match(input kind_e k,
                                      input logic [PRIORITY_WIDTH-1:0] entry,
                                      input logic [PRIORITY_WIDTH-1:0] ref_p);
    logic hit;
    hit = 1'b0;
    case (k)
      KIND_POP:      hit = 1'b1;
      KIND_EQUAL:    hit = (entry == ref_p);
      KIND_AT_LEAST: hit = (entry >= ref_p);
      default:       hit = 1'b0;
    endcase
    return hit;
  endfunction

  logic [DATA_WIDTH-1:0]     data_q [CAPACITY];
  logic [DATA_WIDTH-1:0]     data_d [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] prio_q [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] prio_d [CAPACITY];
  logic [CAPACITY-1:0]       occ;
  logic [CAPACITY-1:0]       ge;
  logic [CNT_W-1:0]          count_q, count_d;

  kind_e                     kind_q;
  logic [PRIORITY_WIDTH-1:0] ref_prio_q;

  logic [DATA_WIDTH-1:0]     out_data_q, out_data_d;
  logic [PRIORITY_WIDTH-1:0] out_prio_q, out_prio_d;
  status_e                   out_status_q, out_status_d;
  logic                      last_q, last_d;

  // Each cell compares its own entry with the new priority; because the list
  // is sorted, the hits form a prefix and the first miss is the insert slot.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prev_ge;

    assign occ[i] = (CNT_W'(i) < count_q);
    assign ge[i]  = occ[i] && (prio_q[i] >= item_priority_i);

    if (i == 0) begin : g_first
      assign prev_ge = 1'b1;
    end else begin : g_rest
      assign prev_ge = ge[i-1];
    end

    always_comb begin
      data_d[i] = data_q[i];
      prio_d[i] = prio_q[i];
      if (cmd_i.insert_en && !ge[i]) begin
        if (prev_ge) begin
          data_d[i] = item_data_i;
          prio_d[i] = item_priority_i;
        end else begin
          data_d[i] = data_q[(i == 0) ? 0 : i - 1];
          prio_d[i] = prio_q[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd_i.shift_en && (i < CAPACITY - 1)) begin
        data_d[i] = data_q[(i < CAPACITY - 1) ? i + 1 : i];
        prio_d[i] = prio_q[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk_i) begin
      data_q[i] <= data_d[i];
      prio_q[i] <= prio_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear_en) begin
      count_d = '0;
    end else if (cmd_i.insert_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.shift_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      kind_q     <= kind_e'(kind_i);
      ref_prio_q <= item_priority_i;
    end
  end

  assign status_o.full      = (count_q == CNT_W'(CAPACITY));
  assign status_o.front_hit = (count_q != '0)
                              && prio_match(kind_e'(kind_i), prio_q[0], item_priority_i);
  // A pop removes exactly one entry, so it never has a follower.
  assign status_o.next_hit  = (count_q > CNT_W'(1)) && (kind_q != KIND_POP)
                              && prio_match(kind_q, prio_q[1], ref_prio_q);

  always_comb begin
    out_data_d   = out_data_q;
    out_prio_d   = out_prio_q;
    out_status_d = out_status_q;
    last_d       = last_q;
    if (cmd_i.emit_item) begin
      out_data_d   = data_q[0];
      out_prio_d   = prio_q[0];
      out_status_d = STATUS_OK;
      last_d       = !status_o.next_hit;
    end else if (cmd_i.emit_status) begin
      out_data_d   = '0;
      out_prio_d   = '0;
      out_status_d = cmd_i.status_code;
      last_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_prio_q   <= out_prio_d;
    out_status_q <= out_status_d;
    last_q       <= last_d;
  end

  assign out_data_o     = out_data_q;
  assign out_priority_o = out_prio_q;
  assign status_code_o  = out_status_q;
  assign last_o         = last_q;

endmodule

>>> design/sspq_ctrl.sv
module sspq_ctrl
  import sspq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   in_fire;
  kind_e  kind;

  assign kind       = kind_e'(kind_i);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (kind inside {KIND_POP, KIND_EQUAL, KIND_AT_LEAST})
            && status_i.front_hit) begin
          state_d = ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        if (slot_free && !status_i.next_hit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.status_code = STATUS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (kind) inside
            KIND_INSERT: begin
              cmd_o.insert_en   = !status_i.full;
              cmd_o.emit_status = 1'b1;
              cmd_o.status_code = status_i.full ? STATUS_FULL : STATUS_OK;
            end
            KIND_CLEAR: begin
              cmd_o.clear_en    = 1'b1;
              cmd_o.emit_status = 1'b1;
            end
            KIND_POP, KIND_EQUAL, KIND_AT_LEAST: begin
              if (status_i.front_hit) begin
                cmd_o.load_en = 1'b1;
              end else begin
                cmd_o.emit_status = 1'b1;
                cmd_o.status_code = STATUS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REMOVE: begin
        if (slot_free) begin
          cmd_o.emit_item = 1'b1;
          cmd_o.shift_en  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.emit_item || cmd_o.emit_status) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result may only be loaded when the output register is free.
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_item || cmd_o.emit_status) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_no_accept_in_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REMOVE) |-> !in_ready_o)
    else $error("input taken while removing entries");

  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.insert_en && (cmd_o.shift_en || cmd_o.clear_en)))
    else $error("conflicting queue updates");

  a_remove_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_en |=> (state_q == ST_REMOVE))
    else $error("removal not started after command load");

endmodule

>>> design/stable_sorted_priority_queue.sv
// Priority queue of CAPACITY entries kept in descending priority order, with
// equal priorities in arrival order. Insert and clear load their result into
// the result register on transfer, and the next input may follow in the cycle
// after. A pop or extract that removes entries first takes the command, then
// gives one removed entry per cycle while the result register is free, since
// removals always come from the front cell and shift the whole list by one
// place for each entry. A pop or extract that finds nothing gives a single
// result. Each input of a known kind yields at least one result, the final one
// marked by last_o; kinds 5 to 7 are taken and dropped without a result. The
// result stage is a register, so inputs wait while a removal is in progress and
// while that register holds an untaken result.
module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned CAPACITY       = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                kind_i,
  input  logic [DATA_WIDTH-1:0]     item_data_i,
  input  logic [PRIORITY_WIDTH-1:0] item_priority_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DATA_WIDTH-1:0]     out_data_o,
  output logic [PRIORITY_WIDTH-1:0] out_priority_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  sspq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  sspq_datapath #(
    .CAPACITY       (CAPACITY),
    .DATA_WIDTH     (DATA_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .kind_i          (kind_i),
    .item_data_i     (item_data_i),
    .item_priority_i (item_priority_i),
    .out_data_o      (out_data_o),
    .out_priority_o  (out_priority_o),
    .status_code_o   (status_o),
    .last_o          (last_o)
  );

endmodule

>>> verif/tb_top.sv
module tb_top;
  import sspq_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam int unsigned DW  = DATA_WIDTH_DEF;
  localparam int unsigned PW  = PRIORITY_WIDTH_DEF;

  // Kinds outside the known set; the block takes and drops them.
  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 130;
  localparam int unsigned PHASE_LEN    = 24;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  // Percent of cycles idle, per phase: none, sender, receiver, both.
  localparam int unsigned SENDER_IDLE [4]    = '{0, 51, 0, 36};
  localparam int unsigned RECEIVER_STALL [4] = '{0, 0, 51, 36};

  localparam logic [PW-1:0] FILL_PRIO [16] =
    '{15, 0, 7, 7, 15, 3, 0, 7, 12, 3, 15, 1, 7, 0, 9, 7};

  typedef struct packed {
    logic [2:0]    kind;
    logic [DW-1:0] data;
    logic [PW-1:0] prio;
  } command_t;

  typedef struct packed {
    logic [DW-1:0] data;
    logic [PW-1:0] prio;
    status_e       status;
    logic          last;
  } removal_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic          in_valid  = 1'b0;
  logic          out_ready = 1'b0;
  command_t      drive_cmd = '0;
  logic          in_ready_o;
  logic          out_valid_o;
  logic [DW-1:0] out_data_o;
  logic [PW-1:0] out_priority_o;
  logic [1:0]    status_o;
  logic          last_o;

  // Shadow copy of the queue contents.
  logic [DW-1:0] queue_data [CAP];
  logic [PW-1:0] queue_prio [CAP];
  int unsigned   queue_count = 0;

  command_t pending_cmds [$];
  removal_t expected_removals [$];
  command_t next_cmd;
  removal_t oldest_removal;

  int unsigned accepted_cnt = 0;
  int unsigned idle_phase;
  int unsigned error_cnt    = 0;
  int unsigned stall_cycles = 0;

  assign idle_phase = (accepted_cnt / PHASE_LEN) % 4;

  stable_sorted_priority_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .kind_i         (drive_cmd.kind),
    .item_data_i    (drive_cmd.data),
    .item_priority_i(drive_cmd.prio),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_data_o     (out_data_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void expect_removal(logic [DW-1:0] d, logic [PW-1:0] p,
                                         status_e s, logic l);
    removal_t r;
    r.data   = d;
    r.prio   = p;
    r.status = s;
    r.last   = l;
    expected_removals.push_back(r);
  endfunction

  // Take n entries off the front, or report nothing found when n is zero.
  function automatic void remove_front(int unsigned n);
    if (n == 0) begin
      expect_removal('0, '0, STATUS_EMPTY, 1'b1);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        expect_removal(queue_data[i], queue_prio[i], STATUS_OK, (i + 1 == n));
      end
      for (int unsigned i = n; i < queue_count; i++) begin
        queue_data[i - n] = queue_data[i];
        queue_prio[i - n] = queue_prio[i];
      end
      queue_count -= n;
    end
  endfunction

  function automatic void apply_command(command_t c);
    int unsigned pos;
    int unsigned n;
    pos = 0;
    n   = 0;
    case (c.kind)
      KIND_INSERT: begin
        if (queue_count >= CAP) begin
          expect_removal('0, '0, STATUS_FULL, 1'b1);
        end else begin
          // A new entry goes behind every entry of equal or higher priority.
          while (pos < queue_count && queue_prio[pos] >= c.prio) pos++;
          for (int unsigned i = queue_count; i > pos; i--) begin
            queue_data[i] = queue_data[i - 1];
            queue_prio[i] = queue_prio[i - 1];
          end
          queue_data[pos] = c.data;
          queue_prio[pos] = c.prio;
          queue_count++;
          expect_removal('0, '0, STATUS_OK, 1'b1);
        end
      end
      KIND_POP: begin
        remove_front((queue_count > 0) ? 1 : 0);
      end
      KIND_EQUAL: begin
        while (n < queue_count && queue_prio[n] == c.prio) n++;
        remove_front(n);
      end
      KIND_AT_LEAST: begin
        while (n < queue_count && queue_prio[n] >= c.prio) n++;
        remove_front(n);
      end
      KIND_CLEAR: begin
        queue_count = 0;
        expect_removal('0, '0, STATUS_OK, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_error(string msg);
    if (error_cnt < MAX_REPORTS) $display("MISMATCH: %s", msg);
    error_cnt++;
  endfunction

  task automatic add_cmd(logic [2:0] k, logic [DW-1:0] d, logic [PW-1:0] p);
    command_t c;
    c.kind = k;
    c.data = d;
    c.prio = p;
    pending_cmds.push_back(c);
  endtask

  task automatic add_random_cmds();
    int unsigned produced;
    int unsigned seg;
    int unsigned len;
    int unsigned w;
    int unsigned base;
    logic        narrow;
    logic [2:0]  k;
    logic [PW-1:0] p;
    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      // Segments: fill bursts, drain bursts and mixed traffic. A narrow
      // priority band makes equal-priority runs and matches common.
      seg    = $urandom_range(9);
      narrow = 1'($urandom_range(1));
      base   = $urandom_range(13);
      len    = (seg < 3) ? $urandom_range(20, 8) : (seg < 5) ? $urandom_range(8, 3) : 10;
      for (int unsigned j = 0; j < len; j++) begin
        p = narrow ? PW'(base + $urandom_range(2)) : PW'($urandom_range(15));
        w = $urandom_range(99);
        if (seg < 3) begin
          k = (w < 92) ? KIND_INSERT : (w < 96) ? KIND_POP :
              3'(KIND_UNUSED_FIRST + $urandom_range(2));
        end else if (seg < 5) begin
          k = (w < 30) ? KIND_POP : (w < 60) ? KIND_EQUAL :
              (w < 96) ? KIND_AT_LEAST : KIND_CLEAR;
        end else begin
          k = (w < 45) ? KIND_INSERT : (w < 60) ? KIND_POP :
              (w < 72) ? KIND_EQUAL : (w < 86) ? KIND_AT_LEAST :
              (w < 91) ? KIND_CLEAR : 3'(KIND_UNUSED_FIRST + $urandom_range(2));
        end
        add_cmd(k, DW'($urandom()), p);
        if (k < KIND_UNUSED_FIRST) produced++;
      end
    end
  endtask

  // Driver: presents queued commands and updates the shadow queue on transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      drive_cmd <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        apply_command(drive_cmd);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= SENDER_IDLE[idle_phase]) begin
          next_cmd  = pending_cmds.pop_front();
          drive_cmd <= next_cmd;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expected removal.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_removals.size() == 0) begin
          flag_error($sformatf("unexpected result data %h prio %h status %0d last %0d",
                               out_data_o, out_priority_o, status_o, last_o));
        end else begin
          oldest_removal = expected_removals.pop_front();
          if (out_data_o !== oldest_removal.data || out_priority_o !== oldest_removal.prio ||
              status_o !== oldest_removal.status || last_o !== oldest_removal.last) begin
            flag_error($sformatf(
              "expected data %h prio %h status %0d last %0d, got data %h prio %h status %0d last %0d",
              oldest_removal.data, oldest_removal.prio, oldest_removal.status,
              oldest_removal.last, out_data_o, out_priority_o, status_o, last_o));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= RECEIVER_STALL[idle_phase]);
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    // Removals from an empty queue.
    add_cmd(KIND_POP, 16'hFFFF, 4'hF);
    add_cmd(KIND_EQUAL, 16'h0000, 4'h0);
    add_cmd(KIND_AT_LEAST, 16'hFFFF, 4'h0);
    // Fill to capacity with repeated priorities and extreme data words.
    for (int unsigned i = 0; i < CAP; i++) begin
      add_cmd(KIND_INSERT,
              (i == 1) ? 16'h0000 : (i == 2) ? 16'hFFFF : DW'((i * 16'h1357) ^ 16'hA5A5),
              FILL_PRIO[i]);
    end
    // Insert into a full queue is rejected.
    add_cmd(KIND_INSERT, 16'h5A5A, 4'hF);
    // Equal extract with no match, then one that takes the top run.
    add_cmd(KIND_EQUAL, 16'h1234, 4'hE);
    add_cmd(KIND_EQUAL, 16'hFFFF, 4'hF);
    add_cmd(KIND_AT_LEAST, 16'h0000, 4'h7);
    add_cmd(KIND_POP, 16'h0000, 4'h0);
    add_cmd(KIND_UNUSED_FIRST, 16'hFFFF, 4'hF);
    add_cmd(KIND_UNUSED_LAST, 16'h0000, 4'h0);
    add_cmd(KIND_CLEAR, 16'hFFFF, 4'hF);
    add_cmd(KIND_POP, 16'h0000, 4'h0);
    add_random_cmds();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_removals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
